### rtl/psb_pkg.sv
// ----------------------------------------------------------------------------
// psb_pkg
// Shared constants, types and the control store for the prime sieve block.
// ----------------------------------------------------------------------------
package psb_pkg;

  // map size and derived widths
  localparam int MAX_NUMBER = 1024;
  localparam int ADDR_W     = $clog2(MAX_NUMBER);
  localparam int NUM_W      = 10;
  localparam int P_W        = ADDR_W / 2 + 2;
  localparam int SQ_W       = 2 * P_W;
  localparam int CMP_A      = (SQ_W > ADDR_W + 2) ? SQ_W : ADDR_W + 2;
  localparam int CMP_W      = (CMP_A > NUM_W + 1) ? CMP_A : NUM_W + 1;

  localparam logic [CMP_W-1:0] MAX_M1    = CMP_W'(MAX_NUMBER - 1);
  localparam logic [NUM_W-1:0] UL_RESET  = NUM_W'(1023);
  localparam logic [P_W-1:0]   FIRST_ODD = P_W'(3);

  // opcode of an input beat
  localparam logic OPC_BUILD = 1'b0;
  localparam logic OPC_QUERY = 1'b1;

  // program counter and step addresses
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] ST_IDLE   = PC_W'(0);
  localparam logic [PC_W-1:0] ST_DISP   = PC_W'(1);
  localparam logic [PC_W-1:0] ST_CLR_N  = PC_W'(2);
  localparam logic [PC_W-1:0] ST_FILL   = PC_W'(3);
  localparam logic [PC_W-1:0] ST_SET_P  = PC_W'(4);
  localparam logic [PC_W-1:0] ST_PCHK   = PC_W'(5);
  localparam logic [PC_W-1:0] ST_PTEST  = PC_W'(6);
  localparam logic [PC_W-1:0] ST_MARK   = PC_W'(7);
  localparam logic [PC_W-1:0] ST_NEXT_P = PC_W'(8);
  localparam logic [PC_W-1:0] ST_BDONE  = PC_W'(9);
  localparam logic [PC_W-1:0] ST_QRD    = PC_W'(10);
  localparam logic [PC_W-1:0] ST_QOUT   = PC_W'(11);

  // datapath operation of a step
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_CLR_N,
    OP_FILL,
    OP_SET_P,
    OP_READ_P,
    OP_MARK,
    OP_NEXT_P,
    OP_BUILD_DONE,
    OP_QUERY_RD,
    OP_QUERY_OUT
  } dp_op_t;

  // jump condition of a step; no jump means fall through to pc + 1
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_START,
    COND_IS_QUERY,
    COND_N_NE_LIM,
    COND_SQ_GT_LIM,
    COND_COMPOSITE,
    COND_M_STEP_LE
  } cond_t;

  typedef struct packed {
    dp_op_t          op;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctrl_t;

  // control store
  function automatic ctrl_t ctrl_rom(input logic [PC_W-1:0] pc);
    ctrl_t w;
    case (pc)
      ST_IDLE:   w = '{OP_ACCEPT,     COND_NO_START,  ST_IDLE};
      ST_DISP:   w = '{OP_NONE,       COND_IS_QUERY,  ST_QRD};
      ST_CLR_N:  w = '{OP_CLR_N,      COND_NEVER,     ST_IDLE};
      ST_FILL:   w = '{OP_FILL,       COND_N_NE_LIM,  ST_FILL};
      ST_SET_P:  w = '{OP_SET_P,      COND_NEVER,     ST_IDLE};
      ST_PCHK:   w = '{OP_READ_P,     COND_SQ_GT_LIM, ST_BDONE};
      ST_PTEST:  w = '{OP_NONE,       COND_COMPOSITE, ST_NEXT_P};
      ST_MARK:   w = '{OP_MARK,       COND_M_STEP_LE, ST_MARK};
      ST_NEXT_P: w = '{OP_NEXT_P,     COND_ALWAYS,    ST_PCHK};
      ST_BDONE:  w = '{OP_BUILD_DONE, COND_ALWAYS,    ST_IDLE};
      ST_QRD:    w = '{OP_QUERY_RD,   COND_NEVER,     ST_IDLE};
      ST_QOUT:   w = '{OP_QUERY_OUT,  COND_ALWAYS,    ST_IDLE};
      default:   w = '{OP_NONE,       COND_ALWAYS,    ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

### rtl/prime_sieve_bitmap.sv
// query: dispatch, map read, output step and result strobe; no new beat until idle
// build: the map is filled with the initial marking up to the limit, then each unmarked
//   odd candidate p with p*p up to the limit has its multiples from p*p on marked
// reset: sequencer idle, limit back to 1023, sieve marked not built; map contents
//   are left as is, since a build rewrites every entry up to the limit
// results are strobed for one cycle on done; the receiver cannot stall
// ----------------------------------------------------------------------------
// prime_sieve_bitmap
// Sieve of Eratosthenes over a composite bitmap, run by a microcoded sequencer.
// ----------------------------------------------------------------------------
module prime_sieve_bitmap (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     opcode,
  input  logic [psb_pkg::NUM_W-1:0] query_number,
  input  logic                     cfg_write,
  input  logic [psb_pkg::NUM_W-1:0] cfg_data,
  output logic                     done,
  output logic                     is_prime,
  output logic                     answer_valid
);
  import psb_pkg::*;

  logic [PC_W-1:0]   pc;
  logic [PC_W-1:0]   pc_next;
  ctrl_t             cw;
  logic              jump;
  logic              op_q;
  logic [NUM_W-1:0]  num_q;
  logic [NUM_W-1:0]  upper_limit;
  logic              built;
  logic [ADDR_W-1:0] n;
  logic [P_W-1:0]    p;
  logic [ADDR_W-1:0] m;
  logic              q_ok;
  logic [CMP_W-1:0]  ul_ext;
  logic [CMP_W-1:0]  lim_cmp;
  logic [ADDR_W-1:0] lim;
  logic [SQ_W-1:0]   sq;
  logic [CMP_W-1:0]  m_step;
  logic              base_comp;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic              ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic              ram_rdata;

  // limit in effect, saturated to the map
  assign ul_ext  = CMP_W'(upper_limit);
  assign lim_cmp = (ul_ext > MAX_M1) ? MAX_M1 : ul_ext;
  assign lim     = lim_cmp[ADDR_W-1:0];

  // candidate square and next multiple
  assign sq     = SQ_W'(p) * SQ_W'(p);
  assign m_step = CMP_W'(m) + CMP_W'(p);

  // initial marking: 0, 1 and even numbers other than 2
  assign base_comp = (n[ADDR_W-1:1] == '0) || (!n[0] && (n != ADDR_W'(2)));

  // fetch the control word and resolve the jump
  assign cw = ctrl_rom(pc);

  always_comb begin
    case (cw.cond)
      COND_NEVER:     jump = 1'b0;
      COND_ALWAYS:    jump = 1'b1;
      COND_NO_START:  jump = !start;
      COND_IS_QUERY:  jump = (op_q == OPC_QUERY);
      COND_N_NE_LIM:  jump = (n != lim);
      COND_SQ_GT_LIM: jump = (CMP_W'(sq) > lim_cmp);
      COND_COMPOSITE: jump = ram_rdata;
      COND_M_STEP_LE: jump = (m_step <= lim_cmp);
      default:        jump = 1'b0;
    endcase
  end

  assign pc_next = jump ? cw.target : pc + PC_W'(1);
  assign busy    = (pc != ST_IDLE);

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // map memory ports
  assign ram_we    = (cw.op == OP_FILL) || (cw.op == OP_MARK);
  assign ram_waddr = (cw.op == OP_FILL) ? n : m;
  assign ram_wdata = (cw.op == OP_FILL) ? base_comp : 1'b1;
  assign ram_raddr = (cw.op == OP_READ_P) ? ADDR_W'(p) : ADDR_W'(num_q);

  psb_ram #(
    .WIDTH (1),
    .DEPTH (MAX_NUMBER)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control state: limit register, build flag, result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_limit <= UL_RESET;
      built       <= 1'b0;
      done        <= 1'b0;
    end else begin
      done <= (cw.op == OP_BUILD_DONE) || (cw.op == OP_QUERY_OUT);
      if (cfg_write) begin
        upper_limit <= cfg_data;
        built       <= 1'b0;
      end else if (cw.op == OP_BUILD_DONE) begin
        built <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (cw.op)
      OP_ACCEPT: begin
        if (start) begin
          op_q  <= opcode;
          num_q <= query_number;
        end
      end
      OP_CLR_N:  n <= '0;
      OP_FILL:   n <= n + ADDR_W'(1);
      OP_SET_P:  p <= FIRST_ODD;
      OP_READ_P: m <= ADDR_W'(sq);
      OP_MARK:   m <= m_step[ADDR_W-1:0];
      OP_NEXT_P: p <= p + P_W'(2);
      OP_BUILD_DONE: begin
        is_prime     <= 1'b0;
        answer_valid <= 1'b1;
      end
      OP_QUERY_RD: q_ok <= built && (CMP_W'(num_q) <= lim_cmp);
      OP_QUERY_OUT: begin
        is_prime     <= q_ok && !ram_rdata;
        answer_valid <= q_ok;
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/psb_ram.sv
// ----------------------------------------------------------------------------
// psb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module psb_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/psb_checker.sv
// ----------------------------------------------------------------------------
// psb_checker
// Port-level checks of the prime sieve block, bound to the top level.
// ----------------------------------------------------------------------------
module psb_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic is_prime,
  input logic answer_valid
);

  // an accepted beat makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted beat did not raise busy");

  // a result strobe comes with the block idle again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // busy only drops with a result
  a_fall_done: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && $fell(busy) |-> done)
    else $error("busy dropped without a result");

  // a result is a single-cycle strobe
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  // a prime answer is always a valid answer
  a_prime_valid: assert property (@(posedge clk) disable iff (rst)
    done && is_prime |-> answer_valid)
    else $error("prime reported on invalid answer");

endmodule

bind prime_sieve_bitmap psb_checker u_psb_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .is_prime     (is_prime),
  .answer_valid (answer_valid)
);
